// ===== rtl/rfb_pkg.sv =====
`default_nettype none

package rfb_pkg;

  localparam int unsigned RFB_QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_ACCESS_TYPE    = 2'd1;
  localparam logic [1:0] CFG_PARAMETER_CODE = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } item_t;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_ACC,
    PH_PHI,
    PH_PLO,
    PH_BODY,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       fend;
    logic       deq;
    logic       init;
    logic       fold;
  } emit_ctl_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/register_frame_builder_crc16.sv =====
// Frame builder with crc-16/modbus trailer. Payload beats go in through push/full, each
// with a last mark; frame bytes come out through empty/pop, one byte per beat. The first
// payload beat of a frame is preceded by slave_address, access_type and parameter_code
// (high, low); the last is followed by the crc low byte and then the crc high byte, which
// carries frame_end. The output side moves one byte per cycle through a single output
// register, as long as pop drains it; a mid-frame beat yields one byte, a frame's first
// beat five and its last beat three. The input side takes a beat every cycle while the
// QUEUE_DEPTH-entry queue between front and back has room; the first byte a beat causes
// passes through that queue and the output register before it shows on the result ports.
// Configuration writes are taken every cycle (cfg_ready is always high) and the prefix
// registers are read as the prefix goes out.
`default_nettype none

module register_frame_builder_crc16
  import rfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = RFB_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  payload_byte,
  input  wire logic        payload_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       frame_byte,
  output logic             frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]  slave_address;
  logic [7:0]  access_type;
  logic [15:0] parameter_code;
  logic        accept;
  item_t       front_item;
  item_t       head;
  logic        head_valid;
  logic        head_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= 8'd3;
      access_type    <= 8'd6;
      parameter_code <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS:  slave_address  <= cfg_data[7:0];
        CFG_ACCESS_TYPE:    access_type    <= cfg_data[7:0];
        CFG_PARAMETER_CODE: parameter_code <= cfg_data;
        default: begin
          // index beyond the register list: dropped
        end
      endcase
    end
  end

  rfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .item         (front_item)
  );

  rfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_item  (front_item),
    .full     (full),
    .rd_valid (head_valid),
    .rd_item  (head),
    .rd_en    (head_pop)
  );

  rfb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop),
    .slave_address  (slave_address),
    .access_type    (access_type),
    .parameter_code (parameter_code),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

`default_nettype wire

// ===== rtl/rfb_front.sv =====
`default_nettype none

module rfb_front
  import rfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] payload_byte,
  input  wire logic       payload_last,
  output item_t           item
);

  logic in_frame;
  logic in_frame_next;

  always_comb begin
    in_frame_next = in_frame;
    if (accept) begin
      in_frame_next = !payload_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
    end
  end

  // first beat of a frame gets the prefix in the back end
  assign item.data  = payload_byte;
  assign item.last  = payload_last;
  assign item.first = !in_frame;

endmodule

`default_nettype wire

// ===== rtl/rfb_queue.sv =====
`default_nettype none

module rfb_queue
  import rfb_pkg::*;
#(
  parameter int unsigned DEPTH = RFB_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire item_t wr_item,
  output logic       full,
  output logic       rd_valid,
  output item_t      rd_item,
  input  wire logic  rd_en
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr_next;
  logic [CntW-1:0] count_next;

  assign full     = (count == FullCnt);
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (wr_en) begin
      wr_ptr_next = (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_next = (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfb_back.sv =====
`default_nettype none

module rfb_back
  import rfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire item_t       head,
  output logic             head_pop,
  input  wire logic [7:0]  slave_address,
  input  wire logic [7:0]  access_type,
  input  wire logic [15:0] parameter_code,
  output logic [7:0]       frame_byte,
  output logic             frame_end,
  output logic             empty,
  input  wire logic        pop
);

  phase_t      state;
  phase_t      state_next;
  emit_ctl_t   ctl;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        out_valid;
  logic        out_valid_next;
  logic        out_ready;
  logic        fire;

  assign out_ready = !out_valid || pop;
  assign fire      = ctl.emit && out_ready;
  assign head_pop  = ctl.deq && fire;
  assign empty     = !out_valid;

  // what goes out this cycle
  always_comb begin
    ctl      = '0;
    ctl.data = head.data;
    ctl.fold = 1'b1;
    case (state)
      PH_HEAD: begin
        if (head_valid) begin
          ctl.emit = 1'b1;
          if (head.first) begin
            ctl.data = slave_address;
            ctl.init = 1'b1;
          end else begin
            ctl.deq = 1'b1;
          end
        end
      end
      PH_ACC: begin
        ctl.emit = 1'b1;
        ctl.data = access_type;
      end
      PH_PHI: begin
        ctl.emit = 1'b1;
        ctl.data = parameter_code[15:8];
      end
      PH_PLO: begin
        ctl.emit = 1'b1;
        ctl.data = parameter_code[7:0];
      end
      PH_BODY: begin
        ctl.emit = head_valid;
        ctl.deq  = 1'b1;
      end
      PH_CRCLO: begin
        ctl.emit = 1'b1;
        ctl.data = crc[7:0];
        ctl.fold = 1'b0;
      end
      PH_CRCHI: begin
        ctl.emit = 1'b1;
        ctl.data = crc[15:8];
        ctl.fend = 1'b1;
        ctl.fold = 1'b0;
      end
      default: begin
        ctl.emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    if (fire) begin
      case (state)
        PH_HEAD: begin
          if (head.first) begin
            state_next = PH_ACC;
          end else if (head.last) begin
            state_next = PH_CRCLO;
          end
        end
        PH_ACC:   state_next = PH_PHI;
        PH_PHI:   state_next = PH_PLO;
        PH_PLO:   state_next = PH_BODY;
        PH_BODY:  state_next = head.last ? PH_CRCLO : PH_HEAD;
        PH_CRCLO: state_next = PH_CRCHI;
        PH_CRCHI: state_next = PH_HEAD;
        default:  state_next = PH_HEAD;
      endcase
    end
  end

  always_comb begin
    crc_next = crc;
    if (fire && ctl.fold) begin
      crc_next = crc16_byte(ctl.init ? CRC_INIT : crc, ctl.data);
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (fire) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_HEAD;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      crc       <= crc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_byte <= ctl.data;
      frame_end  <= ctl.fend;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfb_checker.sv =====
`default_nettype none

module rfb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] frame_byte,
  input wire logic       frame_end
);

  // beats taken since the last frame end, saturating
  logic [2:0] since_end;
  logic [2:0] since_end_next;

  always_comb begin
    since_end_next = since_end;
    if (pop && !empty) begin
      if (frame_end) begin
        since_end_next = '0;
      end else if (since_end != 3'd7) begin
        since_end_next = since_end + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_end <= '0;
    end else begin
      since_end <= since_end_next;
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not clear after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(frame_byte) && $stable(frame_end))
    else $error("waiting result changed");

  // prefix, one payload byte and crc low byte come before any frame end
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && frame_end |-> since_end >= 3'd6)
    else $error("frame shorter than seven bytes");

endmodule

bind register_frame_builder_crc16 rfb_checker u_rfb_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .frame_byte (frame_byte),
  .frame_end  (frame_end)
);

`default_nettype wire
